// ----- rtl/board_image_checker_unit_defines.svh -----
// Assertion macros for the board image checker.
// Included by the modules that carry concurrent checks.
`ifndef BOARD_IMAGE_CHECKER_UNIT_DEFINES_SVH
`define BOARD_IMAGE_CHECKER_UNIT_DEFINES_SVH

// same-cycle implication
`define BIC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BIC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bic_pkg.sv -----
// Shared constants, codes, types and functions of the board image checker.
// No dependencies.
package bic_pkg;

    localparam int unsigned MAX_PAYLOAD_BYTES = 67108864;
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    localparam int SIG_LEN  = 8;
    localparam int HDR_END  = 40;   // signature plus 32 header bytes
    localparam logic [31:0] FILE_VERSION = 32'd2;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] PH_SIG = 2'd0;
    localparam logic [1:0] PH_HDR = 2'd1;
    localparam logic [1:0] PH_PAY = 2'd2;
    localparam logic [1:0] PH_FIN = 2'd3;

    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_BAD_SIG    = 4'd1;
    localparam logic [3:0] ST_HDR_SHORT  = 4'd2;
    localparam logic [3:0] ST_VERSION    = 4'd3;
    localparam logic [3:0] ST_SIZE       = 4'd4;
    localparam logic [3:0] ST_PAY_SIZE   = 4'd5;
    localparam logic [3:0] ST_DATA_SHORT = 4'd6;
    localparam logic [3:0] ST_EXTRA      = 4'd7;
    localparam logic [3:0] ST_CHECKSUM   = 4'd8;

    localparam logic KIND_CELLS  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic CFG_BOARD_WIDTH  = 1'b0;
    localparam logic CFG_BOARD_HEIGHT = 1'b1;

    // results caused by one item: an optional cells part, then an optional status
    typedef struct packed {
        logic        cells_vld;
        logic [7:0]  cells;
        logic [25:0] byte_index;
        logic        stat_vld;
        logic [3:0]  status;
        logic [63:0] gen;
    } t_rec;

    typedef struct packed {
        logic vld;
        t_rec rec;
    } t_push;

    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0: v = 8'h41;  // A
            3'd1: v = 8'h52;  // R
            3'd2: v = 8'h59;  // Y
            3'd3: v = 8'h4C;  // L
            3'd4: v = 8'h49;  // I
            3'd5: v = 8'h46;  // F
            3'd6: v = 8'h45;  // E
            3'd7: v = 8'h32;  // 2
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // FNV-1a 32 step; the constant multiply reduces to shifts and adds
    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        x = h ^ {24'd0, b};
        return 32'(x * FNV_PRIME);
    endfunction

endpackage

// ----- rtl/bic_in_if.sv -----
// Input item channel of the board image checker.
// Depends on bic_pkg.
interface bic_in_if import bic_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       has_byte;
    logic [7:0] data_byte;
    logic       end_of_file;

    modport source (output valid, output has_byte, output data_byte,
                    output end_of_file, input ready);
    modport sink   (input valid, input has_byte, input data_byte,
                    input end_of_file, output ready);
endinterface

// ----- rtl/bic_out_if.sv -----
// Result item channel of the board image checker.
// Depends on bic_pkg.
interface bic_out_if import bic_pkg::*; ();
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  cells;
    logic [25:0] byte_index;
    logic [3:0]  status;
    logic [63:0] saved_generation;
    logic        final_res;

    modport source (output valid, output kind, output cells, output byte_index,
                    output status, output saved_generation, output final_res,
                    input ready);
    modport sink   (input valid, input kind, input cells, input byte_index,
                    input status, input saved_generation, input final_res,
                    output ready);
endinterface

// ----- rtl/bic_parser.sv -----
// Input register, config registers and file parser state; up to one record per item.
// Depends on bic_pkg, bic_in_if and the assertion macro header.
`include "board_image_checker_unit_defines.svh"

module bic_parser import bic_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bic_in_if.sink            i_in,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [15:0]       i_cfg_wdata,
    input  logic [Q_CW-1:0]   i_q_count,
    output t_push             o_push
);

    logic        r_in_vld, r_has, r_eof;
    logic [7:0]  r_byte;
    logic [15:0] r_bw, r_bh;
    logic [29:0] r_exp;

    logic [1:0]   r_phase, n_phase;
    logic [5:0]   r_hcnt, n_hcnt;
    logic [255:0] r_hdr, n_hdr;
    logic [31:0]  r_hash, n_hash;
    logic [26:0]  r_pcnt, n_pcnt;
    logic [3:0]   r_err, n_err;

    logic [31:0]   area;
    logic [Q_CW:0] level;
    logic          in_fire;
    logic          pay_full;
    logic [3:0]    fin_st;
    t_rec          rec;

    // header fields, little endian, in arrival order
    logic [63:0] psize;
    logic [31:0] stored_sum;
    assign psize      = r_hdr[223:160];
    assign stored_sum = r_hdr[255:224];

    // room for the item in the register plus a new one; closed during reset
    assign level    = {1'b0, i_q_count} + {{Q_CW{1'b0}}, r_in_vld};
    assign i_in.ready = i_rst_n && (level < (Q_CW + 1)'(Q_DEPTH));
    assign in_fire  = i_in.valid && i_in.ready;

    assign area     = {16'd0, r_bw} * {16'd0, r_bh};
    assign pay_full = {37'd0, r_pcnt} >= psize;

    always_comb begin
        n_phase = r_phase;
        n_hcnt  = r_hcnt;
        n_hdr   = r_hdr;
        n_hash  = r_hash;
        n_pcnt  = r_pcnt;
        n_err   = r_err;
        fin_st  = ST_OK;
        rec     = '0;
        if (r_in_vld && r_phase != PH_FIN) begin
            if (r_has && r_err == ST_OK) begin
                case (r_phase)
                    PH_SIG: begin
                        if (r_byte != sig_byte(r_hcnt[2:0])) begin
                            n_err = ST_BAD_SIG;
                        end
                        n_hcnt = r_hcnt + 6'd1;
                        if (r_hcnt == 6'(SIG_LEN - 1)) begin
                            n_phase = PH_HDR;
                        end
                    end
                    PH_HDR: begin
                        n_hdr  = {r_byte, r_hdr[255:8]};
                        n_hcnt = r_hcnt + 6'd1;
                        if (r_hcnt == 6'(HDR_END - 1)) begin
                            if (n_hdr[31:0] != FILE_VERSION) begin
                                n_err = ST_VERSION;
                            end else if (n_hdr[63:32] != {16'd0, r_bw} ||
                                         n_hdr[95:64] != {16'd0, r_bh}) begin
                                n_err = ST_SIZE;
                            end else if (n_hdr[223:160] != {34'd0, r_exp} ||
                                         n_hdr[223:160] > 64'(MAX_PAYLOAD_BYTES)) begin
                                n_err = ST_PAY_SIZE;
                            end else begin
                                n_phase = PH_PAY;
                            end
                        end
                    end
                    PH_PAY: begin
                        if (pay_full) begin
                            n_err = ST_EXTRA;
                        end else begin
                            rec.cells_vld  = 1'b1;
                            rec.cells      = r_byte;
                            rec.byte_index = r_pcnt[25:0];
                            n_hash = fnv_step(r_hash, r_byte);
                            n_pcnt = r_pcnt + 27'd1;
                        end
                    end
                    default: ;
                endcase
            end
            if (r_eof) begin
                fin_st = n_err;
                if (n_err == ST_OK) begin
                    case (n_phase)
                        PH_SIG: fin_st = ST_BAD_SIG;
                        PH_HDR: fin_st = ST_HDR_SHORT;
                        PH_PAY: begin
                            if ({37'd0, n_pcnt} < psize) begin
                                fin_st = ST_DATA_SHORT;
                            end else if (n_hash != stored_sum) begin
                                fin_st = ST_CHECKSUM;
                            end
                        end
                        default: ;
                    endcase
                end
                rec.stat_vld = 1'b1;
                rec.status   = fin_st;
                rec.gen      = (fin_st == ST_OK) ? r_hdr[159:96] : 64'd0;
                n_err        = fin_st;
                n_phase      = PH_FIN;
            end
        end
    end

    assign o_push.vld = rec.cells_vld || rec.stat_vld;
    assign o_push.rec = rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_bw     <= 16'd64;
            r_bh     <= 16'd64;
            r_phase  <= PH_SIG;
            r_hcnt   <= 6'd0;
            r_hash   <= FNV_BASIS;
            r_pcnt   <= 27'd0;
            r_err    <= ST_OK;
        end else begin
            r_in_vld <= in_fire;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BOARD_WIDTH:  r_bw <= i_cfg_wdata;
                    CFG_BOARD_HEIGHT: r_bh <= i_cfg_wdata;
                    default: ;
                endcase
            end
            r_phase <= n_phase;
            r_hcnt  <= n_hcnt;
            r_hash  <= n_hash;
            r_pcnt  <= n_pcnt;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_has  <= i_in.has_byte;
            r_byte <= i_in.data_byte;
            r_eof  <= i_in.end_of_file;
        end
        r_hdr <= n_hdr;
        // expected payload bytes, ceil(w*h/8)
        r_exp <= 30'((33'(area) + 33'd7) >> 3);
    end

    `BIC_ASSERT_NEXT(a_fin_quiet, i_clk, i_rst_n, r_phase == PH_FIN, !o_push.vld, "record after final status")
    `BIC_ASSERT_NEXT(a_err_sticky, i_clk, i_rst_n, r_err != ST_OK && r_phase != PH_FIN, r_err == $past(r_err), "latched error changed")

endmodule

// ----- rtl/bic_out_queue.sv -----
// Result record queue; splits each record into its cells and status result items.
// Depends on bic_pkg, bic_out_if and the assertion macro header.
`include "board_image_checker_unit_defines.svh"

module bic_out_queue import bic_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_push           i_push,
    output logic [Q_CW-1:0] o_count,
    bic_out_if.source       o_out
);

    t_rec            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr, r_rptr;
    logic [Q_CW-1:0] r_count;
    logic            r_cells_done;

    t_rec head;
    logic show_cells, fire, pop;

    assign head       = r_mem[r_rptr];
    assign show_cells = head.cells_vld && !r_cells_done;

    assign o_out.valid            = r_count != '0;
    assign o_out.kind             = show_cells ? KIND_CELLS : KIND_STATUS;
    assign o_out.cells            = show_cells ? head.cells : 8'd0;
    assign o_out.byte_index       = show_cells ? head.byte_index : 26'd0;
    assign o_out.status           = show_cells ? ST_OK : head.status;
    assign o_out.saved_generation = show_cells ? 64'd0 : head.gen;
    assign o_out.final_res        = !show_cells;

    assign fire    = o_out.valid && o_out.ready;
    // record leaves once its last part is taken
    assign pop     = fire && (!show_cells || !head.stat_vld);
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr       <= '0;
            r_rptr       <= '0;
            r_count      <= '0;
            r_cells_done <= 1'b0;
        end else begin
            if (i_push.vld) begin
                r_wptr <= r_wptr + Q_AW'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + Q_AW'(1);
            end
            r_count <= r_count + Q_CW'(i_push.vld) - Q_CW'(pop);
            if (pop) begin
                r_cells_done <= 1'b0;
            end else if (fire && show_cells) begin
                r_cells_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.vld) begin
            r_mem[r_wptr] <= i_push.rec;
        end
    end

    `BIC_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, i_push.vld, r_count < Q_CW'(Q_DEPTH), "push into full queue")
    `BIC_ASSERT_NOW(a_split_state, i_clk, i_rst_n, r_cells_done, head.cells_vld && head.stat_vld && r_count != '0, "half-sent record without status part")

endmodule

// ----- rtl/board_image_checker_unit.sv -----
// Board image checker top level: parses a saved bit-packed board image byte by byte.
// Depends on bic_pkg, bic_in_if, bic_out_if, bic_parser and bic_out_queue.
//
// Input channel i_in carries one file byte (has_byte, data_byte) and an
// end_of_file mark per item. Output channel o_out carries cells results (eight
// alive bits of one payload byte and its byte_index) and one final status
// result (status, saved_generation, final_res) at the end of the file. Cells
// are only meaningful when that final status is ok.
// Board size is set through i_cfg_we / i_cfg_idx / i_cfg_wdata while idle.
// Throughput: one item per cycle while the result queue has room. An item that
// carries the last payload byte and the end mark yields two results, cells first.
// A result is offered after its item has passed the input register, then the queue.
// A four-record result queue decouples the sides; when the receiver stalls
// i_in.ready drops once the queued records plus an item held in the input
// register reach four, and nothing is lost. Synchronous reset holds i_in.ready
// low, returns to waiting for the signature, clears the queue and sets the
// board size to 64 by 64. After the final status every item is taken and
// ignored until the next reset.

module board_image_checker_unit import bic_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bic_in_if.sink      i_in,
    bic_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);

    t_push           push;
    logic [Q_CW-1:0] q_count;

    bic_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_count   (q_count),
        .o_push      (push)
    );

    bic_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_count (q_count),
        .o_out   (o_out)
    );

endmodule

// ----- dv/tb_board_image_checker_unit.sv -----
// Testbench for board_image_checker_unit: streams one saved board image through the
// checker and compares every cells and status item with an in-bench parser model.
// Depends on bic_pkg, bic_in_if, bic_out_if and the board_image_checker_unit RTL.
module tb_board_image_checker_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import bic_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 500_000;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam logic [63:0] MAGIC        = "ARYLIFE2";

    typedef struct packed {
        logic        kind;
        logic [7:0]  cells;
        logic [25:0] byte_index;
        logic [3:0]  status;
        logic [63:0] generation;
        logic        final_res;
    } board_result_t;

    // header as it sits on the wire: byte n of the header is bits [8n +: 8]
    typedef struct packed {
        logic [31:0] stored_sum;
        logic [63:0] payload_size;
        logic [63:0] generation;
        logic [31:0] height;
        logic [31:0] width;
        logic [31:0] version;
    } image_header_t;

    typedef enum int {
        CLOSE_JOINED,
        CLOSE_BARE,
        CLOSE_BAD_SUM,
        CLOSE_SHORT,
        CLOSE_EXTRA
    } file_close_e;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_we;
    logic        cfg_idx;
    logic [15:0] cfg_wdata;

    bic_in_if  in_ch ();
    bic_out_if out_ch ();

    board_image_checker_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // parser model state
    logic [15:0]   board_cols;
    logic [15:0]   board_rows;
    logic [1:0]    parse_phase;
    int unsigned   header_bytes;
    image_header_t header_seen;
    logic [31:0]   payload_hash;
    int unsigned   payload_seen;
    logic [3:0]    latched_error;
    board_result_t expected_results[$];

    // stimulus plan
    image_header_t file_header;
    logic [7:0]    image_bytes[];
    logic [15:0]   plan_cols;
    logic [15:0]   plan_rows;
    int unsigned   next_byte;
    int unsigned   body_end;
    file_close_e   close_kind;

    bit          feed_steady;
    bit          drain_steady;
    int unsigned failures;
    int unsigned cycle_count;

    function automatic void note_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS) $display("mismatch %0d: %s", failures, msg);
    endfunction

    function automatic logic [31:0] fnv1a_mix(input logic [31:0] h, input logic [7:0] b);
        return (h ^ 32'(b)) * FNV_PRIME;
    endfunction

    function automatic void clear_model();
        board_cols    = 16'd64;
        board_rows    = 16'd64;
        parse_phase   = PH_SIG;
        header_bytes  = 0;
        header_seen   = '0;
        payload_hash  = FNV_BASIS;
        payload_seen  = 0;
        latched_error = ST_OK;
    endfunction

    function automatic void close_header();
        logic [63:0] need;
        if (header_seen.version != FILE_VERSION) begin
            latched_error = ST_VERSION;
        end else if (header_seen.width != 32'(board_cols) ||
                     header_seen.height != 32'(board_rows)) begin
            latched_error = ST_SIZE;
        end else begin
            need = (64'(board_cols) * 64'(board_rows) + 64'd7) >> 3;
            if (header_seen.payload_size != need ||
                header_seen.payload_size > 64'(MAX_PAYLOAD_BYTES)) begin
                latched_error = ST_PAY_SIZE;
            end else begin
                parse_phase = PH_PAY;
            end
        end
    endfunction

    // byte first, then the end mark; at most two results per item
    function automatic void absorb_item(input logic has, input logic [7:0] b,
                                        input logic eof);
        logic [3:0] st;
        if (parse_phase == PH_FIN) return;
        if (has && latched_error == ST_OK) begin
            case (parse_phase)
                PH_SIG: begin
                    if (b != MAGIC[63 - 8 * header_bytes -: 8]) latched_error = ST_BAD_SIG;
                    header_bytes++;
                    if (header_bytes == SIG_LEN) parse_phase = PH_HDR;
                end
                PH_HDR: begin
                    header_seen[8 * (header_bytes - SIG_LEN) +: 8] = b;
                    header_bytes++;
                    if (header_bytes == HDR_END) close_header();
                end
                default: begin
                    if (64'(payload_seen) >= header_seen.payload_size) begin
                        latched_error = ST_EXTRA;
                    end else begin
                        expected_results.push_back('{KIND_CELLS, b, 26'(payload_seen),
                                                     ST_OK, 64'd0, 1'b0});
                        payload_hash = fnv1a_mix(payload_hash, b);
                        payload_seen++;
                    end
                end
            endcase
        end
        if (eof) begin
            st = latched_error;
            if (st == ST_OK) begin
                if (parse_phase == PH_SIG) st = ST_BAD_SIG;
                else if (parse_phase == PH_HDR) st = ST_HDR_SHORT;
                else if (64'(payload_seen) < header_seen.payload_size) st = ST_DATA_SHORT;
                else if (payload_hash != header_seen.stored_sum) st = ST_CHECKSUM;
            end
            latched_error = st;
            expected_results.push_back('{KIND_STATUS, 8'd0, 26'd0, st,
                                         (st == ST_OK) ? header_seen.generation : 64'd0,
                                         1'b1});
            parse_phase = PH_FIN;
        end
    endfunction

    // one image per run: the checker ignores everything after its status until reset
    function automatic void plan_image();
        int unsigned   cols;
        int unsigned   rows;
        int unsigned   area;
        int unsigned   spare;
        int unsigned   pick;
        logic [31:0]   digest;
        logic [63:0]   gen;
        cols = $urandom_range(1, 120);
        area = $urandom_range(6400, 7000);
        rows = (area + cols - 1) / cols;
        if ($urandom_range(0, 1) == 1) begin
            spare = cols;
            cols  = rows;
            rows  = spare;
        end
        plan_cols = 16'(cols);
        plan_rows = 16'(rows);
        image_bytes = new[(cols * rows + 7) / 8];
        foreach (image_bytes[k]) image_bytes[k] = 8'($urandom);
        image_bytes[0] = 8'h00;
        image_bytes[1] = 8'hFF;
        image_bytes[2] = 8'h01;
        image_bytes[3] = 8'h80;
        image_bytes[4] = 8'hAA;
        image_bytes[5] = 8'h55;
        digest = FNV_BASIS;
        foreach (image_bytes[k]) digest = fnv1a_mix(digest, image_bytes[k]);

        pick = $urandom_range(0, 9);
        if (pick < 4) close_kind = CLOSE_JOINED;
        else if (pick < 6) close_kind = CLOSE_BARE;
        else if (pick < 7) close_kind = CLOSE_BAD_SUM;
        else if (pick < 8) close_kind = CLOSE_SHORT;
        else close_kind = CLOSE_EXTRA;
        if (close_kind == CLOSE_BAD_SUM) digest ^= 32'd1 << $urandom_range(0, 31);

        gen = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0) gen = '1;
        file_header = '{stored_sum: digest, payload_size: 64'(image_bytes.size()),
                        generation: gen, height: 32'(rows), width: 32'(cols),
                        version: FILE_VERSION};
        body_end = image_bytes.size() - 1;
        if (close_kind == CLOSE_SHORT) body_end -= $urandom_range(1, 5);
        next_byte = 0;
    endfunction

    function automatic void pick_pacing();
        feed_steady  = ($urandom_range(0, 3) == 0);
        drain_steady = ($urandom_range(0, 3) == 0);
    endfunction

    function automatic logic [15:0] pick_dim();
        int unsigned r;
        r = $urandom_range(0, 2);
        if (r == 0) return 16'd1;
        if (r == 1) return 16'hFFFF;
        return 16'($urandom_range(1, 65535));
    endfunction

    // valid is left high after an item with no gap, so lower it before idling
    task automatic input_idle();
        in_ch.valid <= 1'b0;
    endtask

    task automatic send_item(input logic has, input logic [7:0] b, input logic eof);
        int unsigned gap;
        in_ch.valid       <= 1'b1;
        in_ch.has_byte    <= has;
        in_ch.data_byte   <= b;
        in_ch.end_of_file <= eof;
        do @(posedge i_clk); while (!in_ch.ready);
        absorb_item(has, b, eof);
        gap = feed_steady ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // both registers, one per cycle, write enable held across the pair
    task automatic set_board(input logic [15:0] cols, input logic [15:0] rows);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_BOARD_WIDTH;
        cfg_wdata <= cols;
        @(posedge i_clk);
        board_cols = cols;
        cfg_idx   <= CFG_BOARD_HEIGHT;
        cfg_wdata <= rows;
        @(posedge i_clk);
        board_rows = rows;
        cfg_we    <= 1'b0;
    endtask

    task automatic test_register_extremes();
        set_board(16'hFFFF, 16'hFFFF);
        feed_steady  = 1'b1;
        drain_steady = 1'b1;
        for (int k = 0; k < 3; k++) send_item(1'b1, MAGIC[63 - 8 * k -: 8], 1'b0);
        input_idle();
        wait_drained();
        set_board(16'd1, 16'd1);
    endtask

    // items with neither byte nor end mark must leave the parser untouched
    task automatic test_bare_items();
        pick_pacing();
        for (int k = 3; k < SIG_LEN; k++) begin
            send_item(1'b0, 8'($urandom), 1'b0);
            send_item(1'b1, MAGIC[63 - 8 * k -: 8], 1'b0);
        end
    endtask

    task automatic test_header();
        input_idle();
        wait_drained();
        set_board(plan_cols, plan_rows);
        pick_pacing();
        for (int h = 0; h < HDR_END - SIG_LEN; h++)
            send_item(1'b1, file_header[8 * h +: 8], 1'b0);
    endtask

    task automatic test_payload_edges();
        feed_steady  = 1'b0;
        drain_steady = 1'b0;
        while (next_byte < 6) begin
            send_item(1'b1, image_bytes[next_byte], 1'b0);
            send_item(1'b0, 8'($urandom), 1'b0);
            next_byte++;
        end
    endtask

    task automatic test_payload_random();
        int unsigned chunk_end;
        while (next_byte < body_end) begin
            pick_pacing();
            chunk_end = next_byte + $urandom_range(60, 160);
            if (chunk_end > body_end) chunk_end = body_end;
            while (next_byte < chunk_end) begin
                if ($urandom_range(0, 19) == 0) send_item(1'b0, 8'($urandom), 1'b0);
                send_item(1'b1, image_bytes[next_byte], 1'b0);
                next_byte++;
            end
            // board size only matters at the header check, so any value is legal here
            input_idle();
            wait_drained();
            set_board(pick_dim(), pick_dim());
        end
    endtask

    task automatic test_file_close();
        pick_pacing();
        case (close_kind)
            CLOSE_BARE: begin
                send_item(1'b1, image_bytes[body_end], 1'b0);
                send_item(1'b0, 8'($urandom), 1'b1);
            end
            CLOSE_EXTRA: begin
                send_item(1'b1, image_bytes[body_end], 1'b0);
                send_item(1'b1, 8'($urandom), 1'b0);
                send_item(1'b1, 8'($urandom), 1'b1);
            end
            default: begin
                send_item(1'b1, image_bytes[body_end], 1'b1);
            end
        endcase
    endtask

    task automatic test_after_status();
        pick_pacing();
        repeat (20) send_item(1'($urandom), 8'($urandom), 1'($urandom));
    endtask

    initial begin : result_sink
        int unsigned stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = drain_steady ? 0 : $urandom_range(0, 14);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    always @(posedge i_clk) begin : result_check
        board_result_t got;
        board_result_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.kind, out_ch.cells, out_ch.byte_index, out_ch.status,
                    out_ch.saved_generation, out_ch.final_res};
            if (expected_results.size() == 0) begin
                note_failure($sformatf("unexpected item %p", got));
            end else begin
                want = expected_results.pop_front();
                if (got !== want)
                    note_failure($sformatf("expected %p, got %p", want, got));
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        failures    = 0;
        cycle_count = 0;
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.has_byte    <= 1'b0;
        in_ch.data_byte   <= 8'd0;
        in_ch.end_of_file <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_idx           <= CFG_BOARD_WIDTH;
        cfg_wdata         <= 16'd0;
        clear_model();
        plan_image();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_extremes();
        test_bare_items();
        test_header();
        test_payload_edges();
        test_payload_random();
        test_file_close();
        test_after_status();

        input_idle();
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (expected_results.size() != 0)
            note_failure($sformatf("%0d items never arrived", expected_results.size()));
        if (failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- board_image_checker_unit.f -----
+incdir+rtl
rtl/bic_pkg.sv
rtl/bic_in_if.sv
rtl/bic_out_if.sv
rtl/bic_parser.sv
rtl/bic_out_queue.sv
rtl/board_image_checker_unit.sv
dv/tb_board_image_checker_unit.sv
